### design/sat_pkg.sv
// shared types and constants of the section address translator
`default_nettype none

package sat_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_V2R  = 2'd1,
		CMD_R2V  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	localparam logic [1:0] CFG_IMAGE_SIZE    = 2'd0;
	localparam logic [1:0] CFG_FILE_SIZE     = 2'd1;
	localparam logic [1:0] CFG_SECTION_COUNT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} sat_state_t;

	typedef struct packed {
		logic [31:0] virt_start;
		logic [31:0] virt_length;
		logic [31:0] raw_start;
		logic [31:0] raw_length;
	} sec_entry_t;

	typedef struct packed {
		logic       en;
		logic [3:0] index;
		sec_entry_t entry;
	} sat_wr_t;

	typedef struct packed {
		logic [31:0] value;
		logic        dir;    // 1: offset to virtual
	} sat_query_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] value;
	} sat_match_t;

endpackage

`default_nettype wire

### design/sat_if.sv
// item channels of the section address translator
`default_nettype none

interface sat_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [3:0]  entry_index;
	logic [31:0] virt_start;
	logic [31:0] virt_length;
	logic [31:0] raw_start;
	logic [31:0] raw_length;
	logic [31:0] query_value;

	modport source (output valid, command, entry_index, virt_start, virt_length, raw_start,
		raw_length, query_value, input ready);
	modport sink (input valid, command, entry_index, virt_start, virt_length, raw_start,
		raw_length, query_value, output ready);
endinterface

interface sat_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] translated;
	logic        hit;

	modport source (output valid, translated, hit, input ready);
	modport sink (input valid, translated, hit, output ready);
endinterface

`default_nettype wire

### design/section_address_translator.sv
// top level of the section address translator
//
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    command, entry_index, virt_start, virt_length,
//                                 raw_start, raw_length, query_value
//  out_ch    out   valid/ready    translated, hit
//  cfg       in    cfg_we         cfg_index, cfg_data (image_size, file_size, section_count)
//
// a load, an unused command, a query over the limit or a query with no entry to scan goes
//   straight to the result register without a scan; a scanning query reads up to n section
//   entries, n = min(section_count[4:0], MAX_SECTIONS), one section entry per cycle through
//   the single table read port and the shared match unit
// one item at a time: in_ch.ready is high only while the sequencer is idle
// the result register lets a new item in while the last result waits on out_ch
// reset clears control and config; the section table is not cleared
`default_nettype none

module section_address_translator
	import sat_pkg::*;
#(
	parameter int MAX_SECTIONS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	sat_in_if.sink           in_ch,
	sat_out_if.source        out_ch
);

	localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

	// load requests into the table
	sat_wr_t          wr;
	// scan read address and the registered entry that the table returns for it
	logic [IDX_W-1:0] rd_addr;
	sec_entry_t       rd_data;
	// held query and the compare/rebase answer for the current entry
	sat_query_t       q;
	sat_match_t       m;

	sat_seq #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.wr       (wr),
		.rd_addr  (rd_addr),
		.q        (q),
		.m        (m)
	);

	sat_table #(
		.MAX_SECTIONS(MAX_SECTIONS)
	) u_table (
		.clk    (clk),
		.wr     (wr),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// first matching section wins: the sequencer stops at the first hit
	sat_match u_match (
		.q(q),
		.e(rd_data),
		.m(m)
	);

endmodule

`default_nettype wire

### design/sat_table.sv
// section table memory, one write port and one registered read port
`default_nettype none

module sat_table
	import sat_pkg::*;
#(
	parameter int MAX_SECTIONS = 16,
	localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
	input  wire logic                 clk,
	input  wire sat_wr_t              wr,
	input  wire logic [IDX_W-1:0]     rd_addr,
	output sec_entry_t                rd_data
);

	sec_entry_t mem [MAX_SECTIONS];
	sec_entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.en && (32'(wr.index) < 32'(MAX_SECTIONS))) begin
			mem[IDX_W'(wr.index)] <= wr.entry;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

### design/sat_match.sv
// shared range check and rebase unit
`default_nettype none

module sat_match
	import sat_pkg::*;
(
	input  wire sat_query_t q,
	input  wire sec_entry_t e,
	output sat_match_t      m
);

	logic [31:0] src_start;
	logic [31:0] src_len;
	logic [31:0] dst_start;
	logic [31:0] src_end;

	always_comb begin
		src_start = q.dir ? e.raw_start   : e.virt_start;
		src_len   = q.dir ? e.raw_length  : e.virt_length;
		dst_start = q.dir ? e.virt_start  : e.raw_start;
		src_end   = src_start + src_len;    // wraps mod 2^32
		m.hit     = (q.value >= src_start) && (q.value < src_end);
		m.value   = q.value - src_start + dst_start;
	end

endmodule

`default_nettype wire

### design/sat_seq.sv
// sequencer: config registers, scan control and result register
`default_nettype none

module sat_seq
	import sat_pkg::*;
#(
	parameter int MAX_SECTIONS = 16,
	localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [31:0]      cfg_data,
	sat_in_if.sink                in_ch,
	sat_out_if.source             out_ch,
	output sat_wr_t               wr,
	output logic [IDX_W-1:0]      rd_addr,
	output sat_query_t            q,
	input  wire sat_match_t       m
);

	localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

	sat_state_t       state_q, state_d;
	logic [31:0]      img_q, fsz_q;
	logic [4:0]       cnt_q;
	logic [CNT_W-1:0] idx_q, n_q, idx_nxt, scan_n;
	logic             pend_q, last_q;
	logic [31:0]      v_q, res_q, out_val_q;
	logic             dir_q, hit_q, out_hit_q, out_valid_q;
	logic             acc, start_scan, issue, done, match_ok, out_load, in_rdy;

	// most entries that a scan reads
	assign scan_n  = (32'(cnt_q) > 32'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS) : CNT_W'(cnt_q);
	assign idx_nxt = idx_q + CNT_W'(1);

	assign acc        = in_ch.valid && in_rdy;
	assign start_scan = (scan_n != '0) &&
		(((in_ch.command == CMD_V2R) && (in_ch.query_value <= img_q)) ||
		 ((in_ch.command == CMD_R2V) && (in_ch.query_value <= fsz_q)));
	assign match_ok   = pend_q && m.hit;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc) begin
				state_d = start_scan ? ST_SCAN : ST_FIN;
			end
			ST_SCAN: if (done) begin
				state_d = ST_FIN;
			end
			ST_FIN: if (out_load) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_rdy   = 1'b0;
		issue    = 1'b0;
		done     = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: in_rdy = 1'b1;
			ST_SCAN: begin
				issue = idx_q < n_q;
				done  = match_ok || (pend_q && last_q);
			end
			ST_FIN: out_load = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			img_q       <= '0;
			fsz_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			pend_q      <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_SIZE:    img_q <= cfg_data;
					CFG_FILE_SIZE:     fsz_q <= cfg_data;
					CFG_SECTION_COUNT: cnt_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (acc) begin
				idx_q  <= '0;
				n_q    <= scan_n;
				pend_q <= 1'b0;
				last_q <= 1'b0;
			end else begin
				pend_q <= issue;
				if (issue) begin
					idx_q  <= idx_nxt;
					last_q <= idx_nxt == n_q;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			v_q   <= in_ch.query_value;
			dir_q <= in_ch.command == CMD_R2V;
			res_q <= '0;
			hit_q <= 1'b0;
		end else if (done) begin
			res_q <= match_ok ? m.value : '0;
			hit_q <= match_ok;
		end
		if (out_load) begin
			out_val_q <= res_q;
			out_hit_q <= hit_q;
		end
	end

	assign in_ch.ready       = in_rdy;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.translated = out_val_q;
	assign out_ch.hit        = out_hit_q;

	assign wr.en                = acc && (in_ch.command == CMD_LOAD);
	assign wr.index             = in_ch.entry_index;
	assign wr.entry.virt_start  = in_ch.virt_start;
	assign wr.entry.virt_length = in_ch.virt_length;
	assign wr.entry.raw_start   = in_ch.raw_start;
	assign wr.entry.raw_length  = in_ch.raw_length;

	assign rd_addr = idx_q[IDX_W-1:0];
	assign q.value = v_q;
	assign q.dir   = dir_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= n_q)
		else $error("scan index past section count");

	a_pend_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && pend_q) |-> idx_q != '0)
		else $error("entry pending without an issued read");

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |=> state_q != ST_IDLE)
		else $error("scan left without a result");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !hit_q) |-> res_q == '0)
		else $error("miss with nonzero result");

endmodule

`default_nettype wire
